// ===== design/lpi_pkg.sv =====
// ----------------------------------------------------------------------------
// lpi_pkg
// shared types and the axis count for the line and plane intersection unit
// ----------------------------------------------------------------------------
package lpi_pkg;

  typedef struct packed {
    logic parallel;
    logic overflow;
  } lpi_flags_t;

  localparam int unsigned NUM_AXES = 3;

endpackage

// ===== design/line_plane_intersection_unit.sv =====
// ----------------------------------------------------------------------------
// line_plane_intersection_unit
// intersection of a line with a plane in signed fixed point
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat carries a plane (normal and
// offset d) and a line (base point and direction), all signed fixed point of
// COORD_WIDTH bits with FRAC_BITS fraction bits.
// Result channel (out_valid/out_ready): one beat per input beat, in order,
// with the hit point, the parallel flag (denominator zero, point zero) and
// the overflow flag (a coordinate saturated).
// The pipe has two product stages, sum, numerator, magnitude, range check,
// one restoring divider stage per quotient bit, and the output register.
// Throughput is one beat per cycle while the receiver keeps out_ready high;
// every stage holds its own valid bit. When the receiver stalls, a stage only
// holds if the stage after it is full and held, so bubbles close up and the
// input keeps being taken until the whole pipe is full.
// Reset clears all valid bits; no result is shown after reset until an input
// beat has passed the pipe.
// ----------------------------------------------------------------------------
module line_plane_intersection_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_normal_x,
  input  logic signed [COORD_WIDTH-1:0] in_normal_y,
  input  logic signed [COORD_WIDTH-1:0] in_normal_z,
  input  logic signed [COORD_WIDTH-1:0] in_plane_offset,
  input  logic signed [COORD_WIDTH-1:0] in_dir_x,
  input  logic signed [COORD_WIDTH-1:0] in_dir_y,
  input  logic signed [COORD_WIDTH-1:0] in_dir_z,
  input  logic signed [COORD_WIDTH-1:0] in_base_x,
  input  logic signed [COORD_WIDTH-1:0] in_base_y,
  input  logic signed [COORD_WIDTH-1:0] in_base_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_hit_x,
  output logic signed [COORD_WIDTH-1:0] out_hit_y,
  output logic signed [COORD_WIDTH-1:0] out_hit_z,
  output logic                          out_parallel,
  output logic                          out_overflow
);

  localparam int W  = COORD_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int NA = lpi_pkg::NUM_AXES;
  localparam int PW = 2 * W;
  localparam int DW = 2 * W + 2;
  localparam int SW = ((2 * W > W + F) ? 2 * W : W + F) + 2;
  localparam int LW = 2 * W + 1;
  localparam int NW = W + SW + 1;
  localparam int NS = W + 7;
  localparam int ST_DIV = 5;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld_r[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage a: plane and line products
  logic signed [W-1:0]  in_dir  [NA];
  logic signed [W-1:0]  in_base [NA];
  logic signed [W-1:0]  in_nrm  [NA];
  logic signed [PW-1:0] pd_r    [NA];
  logic signed [PW-1:0] ps_r    [NA];
  logic signed [W-1:0]  dir_a_r [NA];
  logic signed [W-1:0]  base_a_r[NA];
  logic signed [W-1:0]  off_a_r;

  assign in_dir[0]  = in_dir_x;
  assign in_dir[1]  = in_dir_y;
  assign in_dir[2]  = in_dir_z;
  assign in_base[0] = in_base_x;
  assign in_base[1] = in_base_y;
  assign in_base[2] = in_base_z;
  assign in_nrm[0]  = in_normal_x;
  assign in_nrm[1]  = in_normal_y;
  assign in_nrm[2]  = in_normal_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < NA; c++) begin
        pd_r[c]     <= in_dir[c] * in_nrm[c];
        ps_r[c]     <= in_nrm[c] * in_base[c];
        dir_a_r[c]  <= in_dir[c];
        base_a_r[c] <= in_base[c];
      end
      off_a_r <= in_plane_offset;
    end
  end

  // stage b: denominator and plane value at the base point
  logic signed [DW-1:0] den_b_r;
  logic signed [SW-1:0] s_b_r;
  logic signed [W-1:0]  dir_b_r [NA];
  logic signed [W-1:0]  base_b_r[NA];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      den_b_r <= DW'(pd_r[0]) + DW'(pd_r[1]) + DW'(pd_r[2]);
      s_b_r   <= SW'(ps_r[0]) + SW'(ps_r[1]) + SW'(ps_r[2]) + (SW'(off_a_r) <<< F);
      for (int c = 0; c < NA; c++) begin
        dir_b_r[c]  <= dir_a_r[c];
        base_b_r[c] <= base_a_r[c];
      end
    end
  end

  // stage c: split products for the numerators
  logic signed [LW-1:0] xdl_r[NA];
  logic signed [DW-1:0] xdh_r[NA];
  logic signed [LW-1:0] asl_r[NA];
  logic signed [SW-1:0] ash_r[NA];
  logic signed [DW-1:0] den_c_r;

  logic        [W-1:0]    den_lo;
  logic signed [DW-W-1:0] den_hi;
  logic        [W-1:0]    s_lo;
  logic signed [SW-W-1:0] s_hi;

  assign den_lo = den_b_r[W-1:0];
  assign den_hi = den_b_r[DW-1:W];
  assign s_lo   = s_b_r[W-1:0];
  assign s_hi   = s_b_r[SW-1:W];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int c = 0; c < NA; c++) begin
        xdl_r[c] <= base_b_r[c] * $signed({1'b0, den_lo});
        xdh_r[c] <= base_b_r[c] * den_hi;
        asl_r[c] <= dir_b_r[c] * $signed({1'b0, s_lo});
        ash_r[c] <= dir_b_r[c] * s_hi;
      end
      den_c_r <= den_b_r;
    end
  end

  // stage d: numerators
  logic signed [NW-1:0] num_d_r[NA];
  logic signed [DW-1:0] den_d_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int c = 0; c < NA; c++) begin
        num_d_r[c] <= (NW'(xdh_r[c]) <<< W) + NW'(xdl_r[c])
                    - (NW'(ash_r[c]) <<< W) - NW'(asl_r[c]);
      end
      den_d_r <= den_c_r;
    end
  end

  // stage e: magnitudes and signs
  logic [NW-1:0] mag_e_r[NA];
  logic          neg_e_r[NA];
  logic [DW-1:0] dab_e_r;
  logic          par_e_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < NA; c++) begin
        mag_e_r[c] <= num_d_r[c][NW-1] ? NW'(-num_d_r[c]) : NW'(num_d_r[c]);
        neg_e_r[c] <= num_d_r[c][NW-1] ^ den_d_r[DW-1];
      end
      dab_e_r <= den_d_r[DW-1] ? DW'(-den_d_r) : DW'(den_d_r);
      par_e_r <= (den_d_r == '0);
    end
  end

  // divider: index 0 is the range check, index j settles quotient bit W-j
  logic [NW-1:0] rem_r[W+1][NA];
  logic [W-1:0]  q_r  [W+1][NA];
  logic          neg_r[W+1][NA];
  logic          hi_r [W+1][NA];
  logic [DW-1:0] dab_r[W+1];
  logic          par_r[W+1];

  always_ff @(posedge clk) begin
    if (en[ST_DIV]) begin
      for (int c = 0; c < NA; c++) begin
        rem_r[0][c] <= mag_e_r[c];
        q_r[0][c]   <= '0;
        neg_r[0][c] <= neg_e_r[c];
        hi_r[0][c]  <= (mag_e_r[c] >= (NW'(dab_e_r) << W));
      end
      dab_r[0] <= dab_e_r;
      par_r[0] <= par_e_r;
    end
  end

  for (genvar j = 1; j <= W; j++) begin : g_div
    logic [NW-1:0] trial;
    logic [NW-1:0] rem_nxt[NA];
    logic [W-1:0]  q_nxt  [NA];

    assign trial = NW'(dab_r[j-1]) << (W - j);

    always_comb begin
      for (int c = 0; c < NA; c++) begin
        q_nxt[c]   = q_r[j-1][c];
        rem_nxt[c] = rem_r[j-1][c];
        if (rem_r[j-1][c] >= trial) begin
          rem_nxt[c]  = rem_r[j-1][c] - trial;
          q_nxt[c][W-j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV+j]) begin
        for (int c = 0; c < NA; c++) begin
          rem_r[j][c] <= rem_nxt[c];
          q_r[j][c]   <= q_nxt[c];
          neg_r[j][c] <= neg_r[j-1][c];
          hi_r[j][c]  <= hi_r[j-1][c];
        end
        dab_r[j] <= dab_r[j-1];
        par_r[j] <= par_r[j-1];
      end
    end
  end

  // output register: sign, saturation, parallel case
  logic signed [W-1:0] hit_r  [NA];
  logic signed [W-1:0] hit_nxt[NA];
  logic [NA-1:0]       sat;
  lpi_pkg::lpi_flags_t flags_r;
  lpi_pkg::lpi_flags_t flags_nxt;

  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    for (int c = 0; c < NA; c++) begin
      sat[c] = hi_r[W][c] || (neg_r[W][c] ? (q_r[W][c] > LIM_NEG) : (q_r[W][c] > LIM_POS));
      if (par_r[W]) begin
        hit_nxt[c] = '0;
      end else if (sat[c]) begin
        hit_nxt[c] = neg_r[W][c] ? $signed(LIM_NEG) : $signed(LIM_POS);
      end else begin
        hit_nxt[c] = neg_r[W][c] ? $signed(-q_r[W][c]) : $signed(q_r[W][c]);
      end
    end
    flags_nxt.parallel = par_r[W];
    flags_nxt.overflow = !par_r[W] && (sat != '0);
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      for (int c = 0; c < NA; c++) begin
        hit_r[c] <= hit_nxt[c];
      end
      flags_r <= flags_nxt;
    end
  end

  assign out_hit_x    = hit_r[0];
  assign out_hit_y    = hit_r[1];
  assign out_hit_z    = hit_r[2];
  assign out_parallel = flags_r.parallel;
  assign out_overflow = flags_r.overflow;

`ifndef SYNTHESIS
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_parallel |-> out_hit_x == '0 && out_hit_y == '0 &&
                                  out_hit_z == '0 && !out_overflow)
    else $error("parallel beat with nonzero point or overflow");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits survive reset");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NS-2] && !par_r[W] && !hi_r[W][0] |-> rem_r[W][0] < NW'(dab_r[W]))
    else $error("divider remainder not below divisor");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(vld_r == '1 && !out_ready))
    else $error("input taken while pipe is full and stalled");
`endif

endmodule
